/* src/sebp_pkg.sv */
package sebp_pkg;

  // Group geometry and fixed code values.
  localparam int unsigned GROUP_SIZE = 7;
  localparam int unsigned QDEPTH     = 2;

  localparam logic [7:0] HIGH_BIT  = 8'h80;
  localparam logic [7:0] CODE_CR   = 8'd13;
  localparam logic [7:0] CODE_LF   = 8'd10;
  localparam logic [7:0] GPL_RESET = 8'd10;

  typedef logic [7:0] byte_t;

  // One finished group, handed from the front end to the emitter.
  typedef struct packed {
    logic [GROUP_SIZE-1:0][7:0] bytes;
    logic [2:0]                 count;
    logic                       crlf;
  } group_t;

  // Head status of the group queue.
  typedef struct packed {
    logic   valid;
    group_t data;
  } qhead_t;

endpackage

/* src/sebp_if.sv */
// Input channel: one raw byte per transaction.
interface sebp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_object;

  modport source (output valid, output data_byte, output end_of_object, input ready);
  modport sink   (input valid, input data_byte, input end_of_object, output ready);
endinterface

// Result channel: one code byte per transaction.
interface sebp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       run_last;

  modport source (output valid, output code_byte, output run_last, input ready);
  modport sink   (input valid, input code_byte, input run_last, output ready);
endinterface

/* src/sebp_front.sv */
module sebp_front import sebp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  sebp_in_if.sink       in_bus,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  logic          push_ready,
  output logic          push_valid,
  output group_t        push_data
);

  localparam logic [2:0] LAST_SLOT = 3'(GROUP_SIZE - 1);

  logic [2:0] fill_r, fill_nxt;
  logic [7:0] lgc_r, lgc_nxt;
  logic [7:0] gpl_r, gpl_nxt;
  byte_t      store_r [GROUP_SIZE-1];
  logic       accept;
  logic       flush;
  logic [8:0] count9;
  logic       crlf;

  assign in_bus.ready = push_ready;
  assign accept       = in_bus.valid && in_bus.ready;
  assign flush        = accept && (fill_r == LAST_SLOT || in_bus.end_of_object);

  // Line counting decides at flush time whether CR LF follows the group.
  assign count9 = {1'b0, lgc_r} + 9'd1;
  assign crlf   = count9 >= {1'b0, gpl_r};

  // Assemble the finished group: stored bytes plus the byte arriving now.
  always_comb begin
    for (int j = 0; j < GROUP_SIZE - 1; j++) begin
      push_data.bytes[j] = (3'(j) < fill_r) ? store_r[j] : in_bus.data_byte;
    end
    push_data.bytes[GROUP_SIZE-1] = in_bus.data_byte;
    push_data.count = fill_r + 3'd1;
    push_data.crlf  = crlf;
  end

  assign push_valid = flush;

  // Next-state logic for fill level, line count and the register.
  always_comb begin
    fill_nxt = fill_r;
    lgc_nxt  = lgc_r;
    gpl_nxt  = cfg_wr_en ? cfg_wr_data : gpl_r;
    if (flush) begin
      fill_nxt = 3'd0;
      if (in_bus.end_of_object || crlf) begin
        lgc_nxt = 8'd0;
      end else begin
        lgc_nxt = count9[7:0];
      end
    end else if (accept) begin
      fill_nxt = fill_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 3'd0;
      lgc_r  <= 8'd0;
      gpl_r  <= GPL_RESET;
    end else begin
      fill_r <= fill_nxt;
      lgc_r  <= lgc_nxt;
      gpl_r  <= gpl_nxt;
    end
  end

  // Byte storage for the group in progress.
  always_ff @(posedge clk) begin
    if (accept && !flush) begin
      store_r[fill_r] <= in_bus.data_byte;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LAST_SLOT)
    else $error("fill level past the last slot");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    flush |=> fill_r == 3'd0)
    else $error("fill level not cleared after a flush");
`endif

endmodule

/* src/sebp_fifo.sv */
module sebp_fifo import sebp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  input  group_t push_data,
  output logic   push_ready,
  input  logic   pop,
  output qhead_t head
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

  group_t           entry_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count_r != CNT_FULL;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head.valid;

  assign head.valid = count_r != '0;
  assign head.data  = entry_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue occupancy past its depth");
`endif

endmodule

/* src/sebp_back.sv */
module sebp_back import sebp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  qhead_t   head,
  output logic     pop,
  sebp_out_if.source out_bus
);

  logic [3:0] pos_r, pos_nxt;
  logic       out_valid_r, out_valid_nxt;
  byte_t      code_r, code_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic       item_last;
  logic [3:0] cnt4;
  logic [2:0] idx;
  byte_t      header;
  byte_t      code_sel;

  assign cnt4 = {1'b0, head.data.count};
  assign idx  = 3'(pos_r - 4'd1);

  // Header: bit j carries bit 7 of data byte j, unused slots are zero.
  always_comb begin
    header = HIGH_BIT;
    for (int j = 0; j < GROUP_SIZE; j++) begin
      if (3'(j) < head.data.count) begin
        header[j] = head.data.bytes[j][7];
      end
    end
  end

  // Select the byte for the current position within the group.
  always_comb begin
    if (pos_r == 4'd0) begin
      code_sel = header;
    end else if (pos_r <= cnt4) begin
      code_sel = head.data.bytes[idx] | HIGH_BIT;
    end else if (pos_r == cnt4 + 4'd1) begin
      code_sel = CODE_CR;
    end else begin
      code_sel = CODE_LF;
    end
  end

  assign item_last = head.data.crlf ? (pos_r == cnt4 + 4'd2) : (pos_r == cnt4);
  assign load      = !out_valid_r || out_bus.ready;
  assign pop       = load && head.valid && item_last;

  // Output register advances whenever it is empty or being taken.
  always_comb begin
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    code_nxt      = code_r;
    last_nxt      = last_r;
    if (load) begin
      out_valid_nxt = head.valid;
      if (head.valid) begin
        code_nxt = code_sel;
        last_nxt = item_last;
        pos_nxt  = item_last ? 4'd0 : pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    last_r <= last_nxt;
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.code_byte = code_r;
  assign out_bus.run_last  = last_r;

`ifndef NO_ASSERTIONS
  a_group_held: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != 4'd0) |-> head.valid)
    else $error("queue head left while its group was being emitted");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (head.valid && pos_r != 4'd0) |-> pos_r <= cnt4 + 4'd2)
    else $error("emit position past the end of the group");

  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r && last_r)
    else $error("group popped without a final byte marked");
`endif

endmodule

/* src/seven_in_eight_byte_packer_top.sv */
// Seven-in-eight byte packer. Raw bytes arrive on in_bus and are collected
// into groups of seven; a full group, or the byte marked end_of_object,
// produces a header byte (bit j = bit 7 of data byte j, bit 7 set) followed
// by the group's bytes with bit 7 forced high, and CR LF after every
// groups_per_line groups (reset value 10; the line count restarts at each
// end of object). run_last marks the final code byte of each group. The
// input side accepts one byte per cycle as long as the two-entry group
// queue has room; the output side emits one code byte per cycle while
// out_bus accepts it, so sustained throughput is set by the single output
// port, and the queue lets the input gather the next group while the
// output still emits the last one. The first code byte of a group passes
// through the group queue and then the output register before it is
// offered. Write groups_per_line through cfg_wr_en/cfg_wr_data
// only while the block is idle.
module seven_in_eight_byte_packer_top import sebp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sebp_in_if.sink     in_bus,
  sebp_out_if.source  out_bus,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic   push_valid;
  logic   push_ready;
  group_t push_data;
  logic   pop;
  qhead_t head;

  // Front end: gathers bytes and tracks line position.
  sebp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push_ready  (push_ready),
    .push_valid  (push_valid),
    .push_data   (push_data)
  );

  // Group queue between the two sides.
  sebp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .head       (head)
  );

  // Back end: emits header, data and line breaks.
  sebp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .pop     (pop),
    .out_bus (out_bus)
  );

endmodule
